@@ rtl/sot_pkg.sv @@
// Shared constants, types and helpers for the segment occlusion test.
package sot_pkg;

   localparam int COORD_WIDTH = 16;
   // Exact widths of each arithmetic step
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * COORD_WIDTH + 2;
   localparam int NORM_W = 2 * COORD_WIDTH + 3;
   localparam int DOT_W  = 3 * COORD_WIDTH + 4;
   localparam int SUM_W  = 3 * COORD_WIDTH + 6;

   localparam int STAGES = 6;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_VIEWER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VIEWER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VIEWER_Z = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } point_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } diff_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
   } norm_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic              in_ready;
      logic              out_valid;
   } pipe_ctrl_type;

   function automatic diff_type point_sub(input point_type b, input point_type a);
      diff_type r;
      r.x = DIFF_W'(b.x) - DIFF_W'(a.x);
      r.y = DIFF_W'(b.y) - DIFF_W'(a.y);
      r.z = DIFF_W'(b.z) - DIFF_W'(a.z);
      return r;
   endfunction

endpackage

@@ rtl/sot_if.sv @@
// Channel interfaces: segment pair requests, results and register writes.
interface sot_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sot_pkg::COORD_WIDTH-1:0] a_start_x;
   logic signed [sot_pkg::COORD_WIDTH-1:0] a_start_y;
   logic signed [sot_pkg::COORD_WIDTH-1:0] a_start_z;
   logic signed [sot_pkg::COORD_WIDTH-1:0] a_end_x;
   logic signed [sot_pkg::COORD_WIDTH-1:0] a_end_y;
   logic signed [sot_pkg::COORD_WIDTH-1:0] a_end_z;
   logic signed [sot_pkg::COORD_WIDTH-1:0] b_start_x;
   logic signed [sot_pkg::COORD_WIDTH-1:0] b_start_y;
   logic signed [sot_pkg::COORD_WIDTH-1:0] b_start_z;
   logic signed [sot_pkg::COORD_WIDTH-1:0] b_end_x;
   logic signed [sot_pkg::COORD_WIDTH-1:0] b_end_y;
   logic signed [sot_pkg::COORD_WIDTH-1:0] b_end_z;

   modport source (
      output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
             b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
      input  ready
   );
   modport sink (
      input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
             b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
      output ready
   );
endinterface

interface sot_rsp_if;
   logic valid;
   logic ready;
   logic seems_crossing;
   logic passes_behind;

   modport source (output valid, seems_crossing, passes_behind, input ready);
   modport sink (input valid, seems_crossing, passes_behind, output ready);
endinterface

interface sot_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sot_pkg::CSR_IDX_W-1:0]      index;
   logic [sot_pkg::COORD_WIDTH-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/sot_pipe_ctrl.sv @@
// Valid bits and per-stage load enables of the elastic pipeline.
module sot_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   out_ready,
   output sot_pkg::pipe_ctrl_type ctrl
);

   logic [sot_pkg::STAGES-1:0] valid_ff;
   logic [sot_pkg::STAGES-1:0] valid_in;
   logic [sot_pkg::STAGES:0]   go;

   // A stage loads when it is empty or its contents move on this cycle
   always_comb begin
      go[sot_pkg::STAGES] = out_ready;
      for (int k = sot_pkg::STAGES - 1; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < sot_pkg::STAGES; k++) begin
         if (go[k]) begin
            valid_in[k] = (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load      = go[sot_pkg::STAGES-1:0];
   assign ctrl.in_ready  = go[0];
   assign ctrl.out_valid = valid_ff[sot_pkg::STAGES-1];

   a_bubble_loads: assert property (@(posedge clock) disable iff (reset)
      (~valid_ff & ~go[sot_pkg::STAGES-1:0]) == '0)
      else $error("empty stage refused to load");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !out_ready) |-> !go[0])
      else $error("request taken while every stage is held");

   a_request_enters: assert property (@(posedge clock) disable iff (reset)
      (in_valid && go[0]) |=> valid_ff[0])
      else $error("accepted request did not enter the first stage");

endmodule

@@ rtl/sot_plane.sv @@
// One plane-side test: normal by cross product, two dot products, sign compare.
module sot_plane (
   input  logic                   clock,
   input  sot_pkg::pipe_ctrl_type ctrl,
   input  sot_pkg::point_type     pt_a,
   input  sot_pkg::point_type     pt_b,
   input  sot_pkg::point_type     pt_c,
   input  sot_pkg::point_type     pt_s,
   input  sot_pkg::point_type     pt_t,
   output logic                   opposite
);

   // stage 0: differences from the plane origin
   sot_pkg::diff_type u_ff, w_ff, ds0_ff, dt0_ff;
   // stage 1: cross-product terms
   logic signed [sot_pkg::PROD_W-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff, pza_ff, pzb_ff;
   sot_pkg::diff_type ds1_ff, dt1_ff;
   // stage 2: normal
   sot_pkg::norm_type n_ff;
   sot_pkg::diff_type ds2_ff, dt2_ff;
   // stage 3: dot-product terms
   logic signed [sot_pkg::DOT_W-1:0] sx_ff, sy_ff, sz_ff, tx_ff, ty_ff, tz_ff;
   // stage 4: side decision
   logic opposite_ff;

   logic signed [sot_pkg::SUM_W-1:0] sum_s, sum_t;
   logic pos_s, neg_s, pos_t, neg_t;

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         u_ff   <= sot_pkg::point_sub(pt_b, pt_a);
         w_ff   <= sot_pkg::point_sub(pt_c, pt_a);
         ds0_ff <= sot_pkg::point_sub(pt_s, pt_a);
         dt0_ff <= sot_pkg::point_sub(pt_t, pt_a);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         pxa_ff <= sot_pkg::PROD_W'(u_ff.y) * sot_pkg::PROD_W'(w_ff.z);
         pxb_ff <= sot_pkg::PROD_W'(u_ff.z) * sot_pkg::PROD_W'(w_ff.y);
         pya_ff <= sot_pkg::PROD_W'(u_ff.z) * sot_pkg::PROD_W'(w_ff.x);
         pyb_ff <= sot_pkg::PROD_W'(u_ff.x) * sot_pkg::PROD_W'(w_ff.z);
         pza_ff <= sot_pkg::PROD_W'(u_ff.x) * sot_pkg::PROD_W'(w_ff.y);
         pzb_ff <= sot_pkg::PROD_W'(u_ff.y) * sot_pkg::PROD_W'(w_ff.x);
         ds1_ff <= ds0_ff;
         dt1_ff <= dt0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         n_ff.x <= sot_pkg::NORM_W'(pxa_ff) - sot_pkg::NORM_W'(pxb_ff);
         n_ff.y <= sot_pkg::NORM_W'(pya_ff) - sot_pkg::NORM_W'(pyb_ff);
         n_ff.z <= sot_pkg::NORM_W'(pza_ff) - sot_pkg::NORM_W'(pzb_ff);
         ds2_ff <= ds1_ff;
         dt2_ff <= dt1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         sx_ff <= sot_pkg::DOT_W'(ds2_ff.x) * sot_pkg::DOT_W'(n_ff.x);
         sy_ff <= sot_pkg::DOT_W'(ds2_ff.y) * sot_pkg::DOT_W'(n_ff.y);
         sz_ff <= sot_pkg::DOT_W'(ds2_ff.z) * sot_pkg::DOT_W'(n_ff.z);
         tx_ff <= sot_pkg::DOT_W'(dt2_ff.x) * sot_pkg::DOT_W'(n_ff.x);
         ty_ff <= sot_pkg::DOT_W'(dt2_ff.y) * sot_pkg::DOT_W'(n_ff.y);
         tz_ff <= sot_pkg::DOT_W'(dt2_ff.z) * sot_pkg::DOT_W'(n_ff.z);
      end
   end

   always_comb begin
      sum_s = sot_pkg::SUM_W'(sx_ff) + sot_pkg::SUM_W'(sy_ff) + sot_pkg::SUM_W'(sz_ff);
      sum_t = sot_pkg::SUM_W'(tx_ff) + sot_pkg::SUM_W'(ty_ff) + sot_pkg::SUM_W'(tz_ff);
      neg_s = sum_s[sot_pkg::SUM_W-1];
      neg_t = sum_t[sot_pkg::SUM_W-1];
      // a point on the plane is on neither side
      pos_s = !neg_s && (sum_s != '0);
      pos_t = !neg_t && (sum_t != '0);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         opposite_ff <= (pos_s && neg_t) || (neg_s && pos_t);
      end
   end

   assign opposite = opposite_ff;

endmodule

@@ rtl/segment_occlusion_test.sv @@
// Top level of the segment occlusion test: registers, three plane tests, result stage.
//
// Usage:
//   req_ch carries one pair of 3D segments (A and B, signed Q8.8 endpoints) per
//   request; rsp_ch returns one result per request, in order: seems_crossing
//   (B appears to cross A from the viewpoint) and passes_behind (it also goes
//   behind A). csr_ch writes the viewpoint: index 0/1/2 = x/y/z; other indices
//   are ignored. Write the viewpoint only while no request is in flight.
//   A request accepted on req_ch passes in order through the six-stage pipeline
//   (differences, cross terms, normal, dot terms, sign test, result) to rsp_ch.
//   Throughput: one request per cycle while rsp_ch.ready is high.
//   Reset clears the viewpoint to the origin and empties the pipeline.
//   When the receiver holds rsp_ch.ready low, the result stays on the port and
//   stages behind it keep filling any gaps; req_ch.ready drops once every stage
//   holds a request.
module segment_occlusion_test (
   input  logic         clock,
   input  logic         reset,
   sot_req_if.sink      req_ch,
   sot_rsp_if.source    rsp_ch,
   sot_csr_if.sink      csr_ch
);

   sot_pkg::pipe_ctrl_type ctrl;
   sot_pkg::point_type     viewer_ff;
   sot_pkg::point_type     p1, p2, q1, q2;
   logic                   opp_view_a, opp_view_b, opp_behind;
   logic                   seems_ff, behind_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            sot_pkg::REG_VIEWER_X: viewer_ff.x <= csr_ch.data;
            sot_pkg::REG_VIEWER_Y: viewer_ff.y <= csr_ch.data;
            sot_pkg::REG_VIEWER_Z: viewer_ff.z <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign p1 = '{x: req_ch.a_start_x, y: req_ch.a_start_y, z: req_ch.a_start_z};
   assign p2 = '{x: req_ch.a_end_x,   y: req_ch.a_end_y,   z: req_ch.a_end_z};
   assign q1 = '{x: req_ch.b_start_x, y: req_ch.b_start_y, z: req_ch.b_start_z};
   assign q2 = '{x: req_ch.b_end_x,   y: req_ch.b_end_y,   z: req_ch.b_end_z};

   sot_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   // B's endpoints either side of the plane through the viewpoint and A
   sot_plane u_view_a (
      .clock (clock), .ctrl (ctrl),
      .pt_a (viewer_ff), .pt_b (p1), .pt_c (p2), .pt_s (q1), .pt_t (q2),
      .opposite (opp_view_a)
   );

   // A's endpoints either side of the plane through the viewpoint and B
   sot_plane u_view_b (
      .clock (clock), .ctrl (ctrl),
      .pt_a (viewer_ff), .pt_b (q1), .pt_c (q2), .pt_s (p1), .pt_t (p2),
      .opposite (opp_view_b)
   );

   // viewpoint and B's far end either side of the plane through A and B's start
   sot_plane u_behind (
      .clock (clock), .ctrl (ctrl),
      .pt_a (p1), .pt_b (p2), .pt_c (q1), .pt_s (viewer_ff), .pt_t (q2),
      .opposite (opp_behind)
   );

   always_ff @(posedge clock) begin
      if (ctrl.load[sot_pkg::STAGES-1]) begin
         seems_ff  <= opp_view_a && opp_view_b;
         behind_ff <= opp_view_a && opp_view_b && opp_behind;
      end
   end

   assign req_ch.ready          = ctrl.in_ready;
   assign rsp_ch.valid          = ctrl.out_valid;
   assign rsp_ch.seems_crossing = seems_ff;
   assign rsp_ch.passes_behind  = behind_ff;

   a_behind_needs_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (!rsp_ch.passes_behind || rsp_ch.seems_crossing))
      else $error("passes_behind without seems_crossing");

   a_unknown_index_ignored: assert property (@(posedge clock) disable iff (reset)
      (csr_ch.valid && csr_ch.index != sot_pkg::REG_VIEWER_X
         && csr_ch.index != sot_pkg::REG_VIEWER_Y
         && csr_ch.index != sot_pkg::REG_VIEWER_Z) |=> $stable(viewer_ff))
      else $error("write to an unknown index changed the viewpoint");

endmodule

@@ tb/occlusion_monitor.sv @@
// Watches the request, result and register channels, predicts each verdict and compares.
module occlusion_monitor (
   input  logic clock,
   input  logic reset,
   sot_req_if   req_ch,
   sot_rsp_if   rsp_ch,
   sot_csr_if   csr_ch,
   output int   outstanding,
   output int   mismatches
);

   // Wide enough for any dot product at the largest coordinate width
   typedef logic signed [127:0] wide_type;
   typedef struct {
      wide_type x;
      wide_type y;
      wide_type z;
   } vec_type;
   typedef struct {
      bit crossing;
      bit behind;
   } verdict_type;

   sot_pkg::point_type viewpoint;
   verdict_type        awaited_verdicts[$];
   int                 results_seen;

   function automatic vec_type widen(sot_pkg::point_type p);
      vec_type r;
      r.x = $signed(p.x);
      r.y = $signed(p.y);
      r.z = $signed(p.z);
      return r;
   endfunction

   function automatic vec_type vec_sub(vec_type a, vec_type b);
      vec_type r;
      r.x = a.x - b.x;
      r.y = a.y - b.y;
      r.z = a.z - b.z;
      return r;
   endfunction

   function automatic int side_of(vec_type d, vec_type n);
      wide_type dot;
      dot = d.x * n.x + d.y * n.y + d.z * n.z;
      if (dot < 0)
         return -1;
      if (dot == 0)
         return 0;
      return 1;
   endfunction

   // True only when s and t lie strictly on opposite sides of the plane through a, b, c
   function automatic bit splits(vec_type a, vec_type b, vec_type c, vec_type s, vec_type t);
      vec_type u;
      vec_type w;
      vec_type n;
      int      s1;
      int      s2;
      u = vec_sub(b, a);
      w = vec_sub(c, a);
      n.x = u.y * w.z - u.z * w.y;
      n.y = u.z * w.x - u.x * w.z;
      n.z = u.x * w.y - u.y * w.x;
      s1 = side_of(vec_sub(s, a), n);
      s2 = side_of(vec_sub(t, a), n);
      return (s1 > 0 && s2 < 0) || (s1 < 0 && s2 > 0);
   endfunction

   function automatic verdict_type predict_occlusion(sot_pkg::point_type eye,
                                                     sot_pkg::point_type a1,
                                                     sot_pkg::point_type a2,
                                                     sot_pkg::point_type b1,
                                                     sot_pkg::point_type b2);
      vec_type     e;
      vec_type     p1;
      vec_type     p2;
      vec_type     q1;
      vec_type     q2;
      verdict_type r;
      e  = widen(eye);
      p1 = widen(a1);
      p2 = widen(a2);
      q1 = widen(b1);
      q2 = widen(b2);
      r.crossing = splits(e, p1, p2, q1, q2) && splits(e, q1, q2, p1, p2);
      r.behind   = r.crossing && splits(p1, p2, q1, e, q2);
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at result %0d: %s", results_seen, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      verdict_type        due;
      sot_pkg::point_type a1;
      sot_pkg::point_type a2;
      sot_pkg::point_type b1;
      sot_pkg::point_type b2;
      if (reset) begin
         viewpoint <= '0;
         awaited_verdicts.delete();
         outstanding <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (awaited_verdicts.size() == 0) begin
               report_mismatch($sformatf("result with no request outstanding (crossing %b behind %b)",
                                         rsp_ch.seems_crossing, rsp_ch.passes_behind));
            end else begin
               due = awaited_verdicts.pop_front();
               if (rsp_ch.seems_crossing !== due.crossing)
                  report_mismatch($sformatf("seems_crossing %b, predicted %b",
                                            rsp_ch.seems_crossing, due.crossing));
               if (rsp_ch.passes_behind !== due.behind)
                  report_mismatch($sformatf("passes_behind %b, predicted %b",
                                            rsp_ch.passes_behind, due.behind));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            a1 = sot_pkg::point_type'{req_ch.a_start_x, req_ch.a_start_y, req_ch.a_start_z};
            a2 = sot_pkg::point_type'{req_ch.a_end_x, req_ch.a_end_y, req_ch.a_end_z};
            b1 = sot_pkg::point_type'{req_ch.b_start_x, req_ch.b_start_y, req_ch.b_start_z};
            b2 = sot_pkg::point_type'{req_ch.b_end_x, req_ch.b_end_y, req_ch.b_end_z};
            awaited_verdicts.push_back(predict_occlusion(viewpoint, a1, a2, b1, b2));
         end
         // the register takes its new value after this edge's request has been judged
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               sot_pkg::REG_VIEWER_X: viewpoint.x <= csr_ch.data;
               sot_pkg::REG_VIEWER_Y: viewpoint.y <= csr_ch.data;
               sot_pkg::REG_VIEWER_Z: viewpoint.z <= csr_ch.data;
               default: ;
            endcase
         end
         outstanding <= awaited_verdicts.size();
      end
   end

endmodule

@@ tb/segment_occlusion_test_tb.sv @@
// Stimulus, viewpoint programming and verdict for the segment occlusion test.
module segment_occlusion_test_tb;

   localparam logic [sot_pkg::CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam int COORD_MAX       = (1 << (sot_pkg::COORD_WIDTH - 1)) - 1;
   localparam int COORD_MIN       = -(1 << (sot_pkg::COORD_WIDTH - 1));
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int STALL_LIMIT     = 2000;
   localparam int CHUNK_ITEMS     = 33;

   typedef struct packed {
      sot_pkg::point_type a_start;
      sot_pkg::point_type a_end;
      sot_pkg::point_type b_start;
      sot_pkg::point_type b_end;
   } segment_pair_type;

   logic               clock;
   logic               reset;
   int                 outstanding;
   int                 mismatches;
   int                 send_idle_pct = 0;
   int                 rsp_idle_pct  = 0;
   int                 hold_requests = 0;
   int                 holds_served  = 0;
   int                 quiet_cycles  = 0;
   sot_pkg::point_type view_now;

   sot_req_if req_ch ();
   sot_rsp_if rsp_ch ();
   sot_csr_if csr_ch ();

   segment_occlusion_test uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   occlusion_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sot_pkg::point_type mk_point(int x, int y, int z);
      sot_pkg::point_type r;
      r.x = sot_pkg::COORD_WIDTH'(x);
      r.y = sot_pkg::COORD_WIDTH'(y);
      r.z = sot_pkg::COORD_WIDTH'(z);
      return r;
   endfunction

   function automatic segment_pair_type pair_of(int ax1, int ay1, int az1,
                                                int ax2, int ay2, int az2,
                                                int bx1, int by1, int bz1,
                                                int bx2, int by2, int bz2);
      segment_pair_type p;
      p.a_start = mk_point(ax1, ay1, az1);
      p.a_end   = mk_point(ax2, ay2, az2);
      p.b_start = mk_point(bx1, by1, bz1);
      p.b_end   = mk_point(bx2, by2, bz2);
      return p;
   endfunction

   function automatic int spread(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic int corner();
      return $urandom_range(1) ? COORD_MAX : COORD_MIN;
   endfunction

   function automatic sot_pkg::point_type any_point();
      return mk_point($urandom, $urandom, $urandom);
   endfunction

   // Build B through a point on the sight line of a point on A, nearer than, farther than or at A
   function automatic segment_pair_type staged_crossing(sot_pkg::point_type v);
      int               eye[3];
      int               a1[3];
      int               a2[3];
      int               hit[3];
      int               d[3];
      int               f;
      int               k;
      segment_pair_type p;
      eye[0] = v.x;
      eye[1] = v.y;
      eye[2] = v.z;
      f = $urandom_range(7, 1);
      k = $urandom_range(12, 4);
      for (int i = 0; i < 3; i++) begin
         a1[i]  = spread(6000);
         a2[i]  = spread(6000);
         d[i]   = spread(3000);
         hit[i] = a1[i] + (a2[i] - a1[i]) * f / 8;
         hit[i] = eye[i] + (hit[i] - eye[i]) * k / 8;
      end
      p.a_start = mk_point(a1[0], a1[1], a1[2]);
      p.a_end   = mk_point(a2[0], a2[1], a2[2]);
      p.b_start = mk_point(hit[0] + d[0], hit[1] + d[1], hit[2] + d[2]);
      p.b_end   = mk_point(hit[0] - d[0], hit[1] - d[1], hit[2] - d[2]);
      return p;
   endfunction

   function automatic segment_pair_type degenerate_pair(sot_pkg::point_type v);
      segment_pair_type p;
      p = staged_crossing(v);
      case ($urandom_range(4))
         0: p.b_end = p.b_start;
         1: p.a_end = p.a_start;
         2: p.b_start = p.a_end;
         3: p.a_start = v;
         default: p.b_end = v;
      endcase
      return p;
   endfunction

   function automatic segment_pair_type random_pair(sot_pkg::point_type v);
      segment_pair_type p;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         p = staged_crossing(v);
      end else if (pick < 75) begin
         p.a_start = any_point();
         p.a_end   = any_point();
         p.b_start = any_point();
         p.b_end   = any_point();
      end else if (pick < 85) begin
         p = degenerate_pair(v);
      end else begin
         p = pair_of(spread(2048), spread(2048), spread(2048), spread(2048), spread(2048),
                     spread(2048), spread(2048), spread(2048), spread(2048), spread(2048),
                     spread(2048), spread(2048));
      end
      return p;
   endfunction

   function automatic sot_pkg::point_type pick_viewpoint(int n);
      sot_pkg::point_type v;
      case (n % 4)
         0: v = mk_point(corner(), corner(), corner());
         1: v = any_point();
         2: v = mk_point(spread(3000), spread(3000), spread(3000));
         default: v = mk_point(0, 0, spread(COORD_MAX));
      endcase
      return v;
   endfunction

   task automatic present(segment_pair_type p);
      req_ch.a_start_x <= p.a_start.x;
      req_ch.a_start_y <= p.a_start.y;
      req_ch.a_start_z <= p.a_start.z;
      req_ch.a_end_x   <= p.a_end.x;
      req_ch.a_end_y   <= p.a_end.y;
      req_ch.a_end_z   <= p.a_end.z;
      req_ch.b_start_x <= p.b_start.x;
      req_ch.b_start_y <= p.b_start.y;
      req_ch.b_start_z <= p.b_start.z;
      req_ch.b_end_x   <= p.b_end.x;
      req_ch.b_end_y   <= p.b_end.y;
      req_ch.b_end_z   <= p.b_end.z;
   endtask

   // Leaves valid high on return so back-to-back requests keep it raised
   task automatic send_pair(segment_pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      present(p);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_reg(logic [sot_pkg::CSR_IDX_W-1:0] idx,
                            logic [sot_pkg::COORD_WIDTH-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_viewpoint(sot_pkg::point_type v);
      write_reg(sot_pkg::REG_VIEWER_X, v.x);
      write_reg(sot_pkg::REG_VIEWER_Y, v.y);
      write_reg(sot_pkg::REG_VIEWER_Z, v.z);
      // a write to the spare index must leave the viewpoint alone
      write_reg(REG_UNMAPPED, sot_pkg::COORD_WIDTH'($urandom));
      csr_ch.valid <= 1'b0;
      view_now = v;
   endtask

   // Hold the sender until every request has produced its result
   task automatic await_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      present('0);
      csr_ch.valid <= 1'b0;
      csr_ch.index <= sot_pkg::REG_VIEWER_X;
      csr_ch.data  <= '0;
      view_now = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // viewpoint still at the origin from reset
      send_pair(pair_of(-1024, 0, 2560, 1024, 0, 2560, 0, -1024, 5120, 0, 1024, 5120));
      send_pair(pair_of(-1024, 0, 2560, 1024, 0, 2560, 0, -1024, 1280, 0, 1024, 1280));
      await_results();

      set_viewpoint(mk_point(0, 0, -2560));
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_pair(pair_of(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX));
      // B crosses A in view, farther away, then nearer, then meeting it, then farther with B reversed
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, 0, -1024, 256, 0, 1024, 256));
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, 0, -1024, -256, 0, 1024, -256));
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, 0, -1024, 0, 0, 1024, 0));
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, 0, 1024, 256, 0, -1024, 256));
      // B grazes the end of A
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, 1024, -1024, 0, 1024, 1024, 0));
      // A lies along the line of sight
      send_pair(pair_of(0, 0, 0, 0, 0, 1024, -512, 0, 512, 512, 0, 512));
      // B in the plane of the eye and A
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, 512, 0, -512, 512, 0, 512));
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, 0, 256, 256, 0, 256, 256));
      send_pair(pair_of(300, 0, 0, 300, 0, 0, 0, -1024, 256, 0, 1024, 256));
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, -1024, 512, 256, 1024, 512, 256));
      send_pair(pair_of(-1024, 0, 0, 1024, 0, 0, -1024, 0, 0, 0, 1024, 256));

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               rsp_idle_pct  = 74;
            end
            1: begin
               send_idle_pct = 74;
               rsp_idle_pct  = 26;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int chunk = 0; chunk < 4; chunk++) begin
            await_results();
            set_viewpoint(pick_viewpoint(phase * 4 + chunk));
            // stall the results long enough to back the pipeline up into the input
            if (phase == 0 && chunk == 1)
               hold_requests++;
            repeat (CHUNK_ITEMS) send_pair(random_pair(view_now));
         end
      end

      await_results();
      repeat (sot_pkg::STAGES + 4) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sot_pkg.sv
rtl/sot_if.sv
rtl/sot_pipe_ctrl.sv
rtl/sot_plane.sv
rtl/segment_occlusion_test.sv
tb/occlusion_monitor.sv
tb/segment_occlusion_test_tb.sv
